// ===== rtl/slswd_pkg.sv =====
// Shared types, widths and constants for the sensor level scaler.
package slswd_pkg;

    // Window depth default
    localparam int WINDOW_LEN_DEF = 5;

    // Field widths
    localparam int MV_W       = 13;
    localparam int LEVEL_W    = 8;
    localparam int DELTA_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_MAX = 2'd1;

    // Register reset values
    localparam logic [MV_W-1:0] IN_MIN_RST = 13'd1500;
    localparam logic [MV_W-1:0] IN_MAX_RST = 13'd4096;

    // Level limits
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
    localparam logic [LEVEL_W-1:0] LEVEL_MID = 8'd128;

    // Shared divider sizing: dividend holds |mv - min| * 255, divisor a 13-bit span
    localparam int DVD_W  = 21;
    localparam int DVS_W  = 13;
    localparam int ITER_W = 5;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [ITER_W-1:0] iters;
    } t_div_ctl;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_sts;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_DSTART,
        ST_DELTA,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/slswd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module slswd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  slswd_pkg::t_div_ctl           i_ctl,
    input  logic [slswd_pkg::DVD_W-1:0]   i_dividend,
    input  logic [slswd_pkg::DVS_W-1:0]   i_divisor,
    output slswd_pkg::t_div_sts           o_sts
);

    localparam int DVD_W  = slswd_pkg::DVD_W;
    localparam int DVS_W  = slswd_pkg::DVS_W;
    localparam int ITER_W = slswd_pkg::ITER_W;

    logic [ITER_W-1:0] r_cnt;
    logic              r_done;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    w_trial;
    logic [DVS_W:0]    w_sub;
    logic              w_ge;

    // Shift in the next dividend bit and try the subtract
    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_sub   = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
    end

    // Count iterations and flag the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_cnt <= i_ctl.iters;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then advance remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_sub[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.quotient = r_quo;

endmodule

// ===== rtl/slswd_window.sv =====
// Ring of recent levels with a running sum.
module slswd_window #(
    parameter int WINDOW_LEN = slswd_pkg::WINDOW_LEN_DEF,
    parameter int SUM_W      = $clog2(255 * WINDOW_LEN + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  logic [slswd_pkg::LEVEL_W-1:0]   i_level,
    output logic [SUM_W-1:0]                o_sum
);

    localparam int LEVEL_W = slswd_pkg::LEVEL_W;
    localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
    localparam logic [SUM_W-1:0]  SUM_RST   = SUM_W'(128 * WINDOW_LEN);

    logic [LEVEL_W-1:0] r_store [WINDOW_LEN];
    logic [SLOT_W-1:0]  r_slot;
    logic [SUM_W-1:0]   r_sum;

    logic [LEVEL_W-1:0] w_old;

    // Read the entry about to be replaced
    assign w_old = r_store[r_slot];

    // Replace the oldest level and update the sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_store[k] <= slswd_pkg::LEVEL_MID;
            end
            r_slot <= '0;
            r_sum  <= SUM_RST;
        end else if (i_push) begin
            r_store[r_slot] <= i_level;
            r_sum  <= r_sum - SUM_W'(w_old) + SUM_W'(i_level);
            r_slot <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== rtl/sensor_level_scale_and_window_delta.sv =====
// Each request runs through the shared serial divider: one pass for the scale, one for the delta.
// An empty or inverted range skips the scale pass.
// One request at a time: the next is taken in the cycle after a result is loaded;
// a zero reading is taken while idle and gives no result.
// Synchronous active-low reset: window entries 128, held level 0, registers at defaults.
module sensor_level_scale_and_window_delta #(
    parameter int WINDOW_LEN = slswd_pkg::WINDOW_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [slswd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [slswd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [slswd_pkg::MV_W-1:0]         i_sample_mv,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [slswd_pkg::LEVEL_W-1:0]      o_level,
    output logic signed [slswd_pkg::DELTA_W-1:0] o_delta
);

    localparam int MV_W    = slswd_pkg::MV_W;
    localparam int LEVEL_W = slswd_pkg::LEVEL_W;
    localparam int DELTA_W = slswd_pkg::DELTA_W;
    localparam int DVD_W   = slswd_pkg::DVD_W;
    localparam int DVS_W   = slswd_pkg::DVS_W;
    localparam int ITER_W  = slswd_pkg::ITER_W;
    localparam int SUM_W   = $clog2(255 * WINDOW_LEN + 1);

    slswd_pkg::t_state r_state, n_state;

    logic [MV_W-1:0]    r_in_min;
    logic [MV_W-1:0]    r_in_max;
    logic [LEVEL_W-1:0] r_held,  n_held;
    logic               r_out_valid, n_out_valid;

    logic [MV_W-1:0]    r_mv,    n_mv;
    logic               r_neg,   n_neg;
    logic               r_dneg,  n_dneg;
    logic [LEVEL_W-1:0] r_level, n_level;
    logic [LEVEL_W-1:0] r_out_level, n_out_level;
    logic [DELTA_W-1:0] r_out_delta, n_out_delta;

    slswd_pkg::t_div_ctl w_div_ctl;
    slswd_pkg::t_div_sts w_div_sts;
    logic [DVD_W-1:0]    w_dividend;
    logic [DVS_W-1:0]    w_divisor;

    logic               w_push;
    logic [SUM_W-1:0]   w_sum;

    logic [MV_W:0]      w_diff;
    logic [MV_W:0]      w_den;
    logic               w_den_ok;
    logic [MV_W:0]      w_mag;
    logic [DVD_W-1:0]   w_num;
    logic [SUM_W-1:0]   w_lw;
    logic [SUM_W:0]     w_dd;
    logic [SUM_W:0]     w_dmag;
    logic [DELTA_W-1:0] w_q9;

    // Hold the range registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_min <= slswd_pkg::IN_MIN_RST;
            r_in_max <= slswd_pkg::IN_MAX_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slswd_pkg::REG_IN_MIN: r_in_min <= i_cfg_data;
                slswd_pkg::REG_IN_MAX: r_in_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Scale operands: |mv - min| * 255 over max - min
    always_comb begin
        w_diff   = {1'b0, r_mv} - {1'b0, r_in_min};
        w_den    = {1'b0, r_in_max} - {1'b0, r_in_min};
        w_den_ok = !w_den[MV_W] && (w_den != '0);
        w_mag    = w_diff[MV_W] ? (~w_diff + 1'b1) : w_diff;
        w_num    = DVD_W'({w_mag[MV_W-1:0], 8'd0}) - DVD_W'(w_mag[MV_W-1:0]);
    end

    // Delta operands: |level * WINDOW_LEN - sum| over WINDOW_LEN
    always_comb begin
        w_lw   = SUM_W'(r_level * WINDOW_LEN);
        w_dd   = {1'b0, w_lw} - {1'b0, w_sum};
        w_dmag = w_dd[SUM_W] ? (~w_dd + 1'b1) : w_dd;
        w_q9   = w_div_sts.quotient[DELTA_W-1:0];
    end

    // Feed the shared divider for either pass
    always_comb begin
        w_div_ctl.start = ((r_state == slswd_pkg::ST_PREP) && w_den_ok)
                          || (r_state == slswd_pkg::ST_DSTART);
        if (r_state == slswd_pkg::ST_PREP) begin
            w_div_ctl.iters = ITER_W'(DVD_W);
            w_dividend      = w_num;
            w_divisor       = w_den[DVS_W-1:0];
        end else begin
            w_div_ctl.iters = ITER_W'(SUM_W);
            w_dividend      = DVD_W'(w_dmag[SUM_W-1:0]) << (DVD_W - SUM_W);
            w_divisor       = DVS_W'(WINDOW_LEN);
        end
    end

    slswd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_sts      (w_div_sts)
    );

    slswd_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .SUM_W      (SUM_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_level (r_level),
        .o_sum   (w_sum)
    );

    // Sequence one request through both divider passes
    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_out_valid = r_out_valid;
        n_mv        = r_mv;
        n_neg       = r_neg;
        n_dneg      = r_dneg;
        n_level     = r_level;
        n_out_level = r_out_level;
        n_out_delta = r_out_delta;
        w_push      = 1'b0;

        // Drop the result once it is taken
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            slswd_pkg::ST_IDLE: begin
                if (i_valid && (i_sample_mv != '0)) begin
                    n_mv    = i_sample_mv;
                    n_state = slswd_pkg::ST_PREP;
                end
            end
            slswd_pkg::ST_PREP: begin
                n_neg = w_diff[MV_W];
                if (w_den_ok) begin
                    n_state = slswd_pkg::ST_SCALE;
                end else begin
                    n_level = r_held;
                    n_state = slswd_pkg::ST_DSTART;
                end
            end
            slswd_pkg::ST_SCALE: begin
                if (w_div_sts.done) begin
                    if (r_neg) begin
                        if (w_div_sts.quotient == '0) begin
                            n_level = '0;
                            n_held  = '0;
                        end else begin
                            n_level = r_held;
                        end
                    end else if (w_div_sts.quotient > DVD_W'(slswd_pkg::LEVEL_MAX)) begin
                        n_level = slswd_pkg::LEVEL_MAX;
                        n_held  = slswd_pkg::LEVEL_MAX;
                    end else begin
                        n_level = w_div_sts.quotient[LEVEL_W-1:0];
                        n_held  = w_div_sts.quotient[LEVEL_W-1:0];
                    end
                    n_state = slswd_pkg::ST_DSTART;
                end
            end
            slswd_pkg::ST_DSTART: begin
                n_dneg  = w_dd[SUM_W];
                n_state = slswd_pkg::ST_DELTA;
            end
            slswd_pkg::ST_DELTA: begin
                if (w_div_sts.done) begin
                    n_state = slswd_pkg::ST_OUT;
                end
            end
            slswd_pkg::ST_OUT: begin
                // Load level and delta together once the output is free;
                // the divider holds its quotient until the next start
                if (!r_out_valid) begin
                    n_out_level = r_level;
                    n_out_delta = r_dneg ? (~w_q9 + 1'b1) : w_q9;
                    n_out_valid = 1'b1;
                    w_push      = 1'b1;
                    n_state     = slswd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = slswd_pkg::ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= slswd_pkg::ST_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_mv        <= n_mv;
        r_neg       <= n_neg;
        r_dneg      <= n_dneg;
        r_level     <= n_level;
        r_out_level <= n_out_level;
        r_out_delta <= n_out_delta;
    end

    assign o_stall = (r_state != slswd_pkg::ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_level = r_out_level;
    assign o_delta = r_out_delta;

endmodule

// ===== rtl/slswd_chk.sv =====
// Port checker for the sensor level scaler, bound to the top level.
module slswd_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 o_stall,
    input logic [slswd_pkg::MV_W-1:0]           i_sample_mv,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic [slswd_pkg::LEVEL_W-1:0]        o_level,
    input logic signed [slswd_pkg::DELTA_W-1:0] o_delta
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_level) && $stable(o_delta))
        else $error("stalled result changed or vanished");

    // Take no new request in the cycle after a nonzero reading
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && (i_sample_mv != '0) |=> o_stall)
        else $error("block ready right after a nonzero request");

    // Never present two results back to back
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |=> !o_valid)
        else $error("result followed another without a gap");

    // Keep delta within the level span
    a_delta_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_delta != -9'sd256))
        else $error("delta out of range");

endmodule

bind sensor_level_scale_and_window_delta slswd_chk u_chk (.*);
